FILE: hw/rtl/kcore_pkg.sv
package kcore_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_ENTRIES = 8192;

    // node index, node count, entry index and count, degree and bin values
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int EW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        REQ_HEADER = 2'd0,
        REQ_ENTRY  = 2'd1,
        REQ_RUN    = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef enum logic [26:0] {
        S_IDLE     = 27'b1 << 0,
        S_DEG_LS   = 27'b1 << 1,
        S_DEG_LSW  = 27'b1 << 2,
        S_DEG_ADJ  = 27'b1 << 3,
        S_DEG_CNT  = 27'b1 << 4,
        S_BIN_CLR  = 27'b1 << 5,
        S_HIST_RD  = 27'b1 << 6,
        S_HIST_BR  = 27'b1 << 7,
        S_HIST_WR  = 27'b1 << 8,
        S_PFX_RD   = 27'b1 << 9,
        S_PFX_WR   = 27'b1 << 10,
        S_PLACE_RD = 27'b1 << 11,
        S_PLACE_BR = 27'b1 << 12,
        S_PLACE_WR = 27'b1 << 13,
        S_SHIFT_RD = 27'b1 << 14,
        S_SHIFT_WR = 27'b1 << 15,
        S_PEEL_RS  = 27'b1 << 16,
        S_PEEL_V   = 27'b1 << 17,
        S_PEEL_DV  = 27'b1 << 18,
        S_PEEL_LS  = 27'b1 << 19,
        S_PEEL_LE  = 27'b1 << 20,
        S_PEEL_ADJ = 27'b1 << 21,
        S_PEEL_U   = 27'b1 << 22,
        S_PEEL_DU  = 27'b1 << 23,
        S_PEEL_PW  = 27'b1 << 24,
        S_PEEL_W   = 27'b1 << 25,
        S_PEEL_SW  = 27'b1 << 26
    } t_state;

endpackage

FILE: hw/rtl/k_core_decomposition_core.sv
// k-core decomposer. Load a graph with header beats (open next node) and neighbor
// beats (append to the open node's list), then send a run beat, then query any
// node's coreness. A beat is taken when start is high and busy is low. A query
// answers on the o_valid strobe in the cycle right after it, one cycle wide, and
// the receiver cannot hold it off. A run holds busy high through the degree,
// histogram, prefix, placement and shift passes and then the peeling pass;
// each step reads memories that have one registered read port each, then
// writes back. Dropped load beats set a sticky overflow flag, kept until reset,
// that each query result reports on o_overflow.
module k_core_decomposition_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_req_type,
    input  logic [kcore_pkg::NW-1:0]   i_neighbor_id,
    input  logic [kcore_pkg::NW-1:0]   i_query_node,
    output logic                       o_valid,
    output logic [kcore_pkg::NW-1:0]   o_node_echo,
    output logic [kcore_pkg::EW-1:0]   o_core_value,
    output logic                       o_in_range,
    output logic                       o_overflow
);
    import kcore_pkg::*;

    // memories
    logic [NW-1:0] m_adj  [MAX_ENTRIES];
    logic [EW-1:0] m_ls   [MAX_NODES];
    logic [EW-1:0] m_deg  [MAX_NODES];
    logic [EW-1:0] m_bin  [MAX_ENTRIES + 1];
    logic [NW-1:0] m_srt  [MAX_NODES];
    logic [NW-1:0] m_pos  [MAX_NODES];
    logic [EW-1:0] m_core [MAX_NODES];

    logic          adj_we, ls_we, deg_we, bin_we, srt_we, pos_we, core_we;
    logic [AW-1:0] adj_wa, adj_ra;
    logic [NW-1:0] ls_wa, ls_ra, deg_wa, deg_ra, srt_wa, srt_ra, pos_wa, pos_ra;
    logic [NW-1:0] core_wa, core_ra;
    logic [EW-1:0] bin_wa, bin_ra;
    logic [NW-1:0] adj_wd, srt_wd, pos_wd;
    logic [EW-1:0] ls_wd, deg_wd, bin_wd, core_wd;

    logic [NW-1:0] r_adj_q, r_srt_q, r_pos_q;
    logic [EW-1:0] r_ls_q, r_deg_q, r_bin_q, r_core_q;

    // control and sequencer state
    t_state        r_state, n_state;
    logic [CW-1:0] r_nc, n_nc, r_v, n_v, r_i, n_i;
    logic [EW-1:0] r_ec, n_ec, r_e, n_e, r_end, n_end, r_cnt, n_cnt;
    logic [EW-1:0] r_maxd, n_maxd, r_d, n_d, r_acc, n_acc, r_dv, n_dv, r_du, n_du;
    logic [NW-1:0] r_pv, n_pv, r_u, n_u, r_pu, n_pu, r_pw, n_pw;
    logic          r_computed, n_computed, r_ovf, n_ovf;

    // result register
    logic          r_valid, n_valid, r_ok, n_ok, r_ovq, n_ovq;
    logic [NW-1:0] r_qnode, n_qnode;

    logic [CW-1:0] vp1, pvp1, ip1;
    logic          accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign vp1    = r_v + CW'(1);
    assign ip1    = r_i + CW'(1);
    assign pvp1   = CW'(r_pv) + CW'(1);

    always_comb begin
        n_state = r_state;  n_nc = r_nc;  n_ec = r_ec;  n_v = r_v;  n_i = r_i;
        n_e = r_e;  n_end = r_end;  n_cnt = r_cnt;  n_maxd = r_maxd;  n_d = r_d;
        n_acc = r_acc;  n_dv = r_dv;  n_du = r_du;  n_pv = r_pv;  n_u = r_u;
        n_pu = r_pu;  n_pw = r_pw;  n_computed = r_computed;  n_ovf = r_ovf;
        n_valid = 1'b0;  n_ok = r_ok;  n_ovq = r_ovq;  n_qnode = r_qnode;

        adj_we = 1'b0;  ls_we = 1'b0;  deg_we = 1'b0;  bin_we = 1'b0;
        srt_we = 1'b0;  pos_we = 1'b0;  core_we = 1'b0;
        adj_wa = '0;  adj_ra = '0;  ls_wa = '0;  ls_ra = '0;  deg_wa = '0;  deg_ra = '0;
        srt_wa = '0;  srt_ra = '0;  pos_wa = '0;  pos_ra = '0;  core_wa = '0;
        core_ra = '0;  bin_wa = '0;  bin_ra = '0;
        adj_wd = '0;  srt_wd = '0;  pos_wd = '0;  ls_wd = '0;  deg_wd = '0;
        bin_wd = '0;  core_wd = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_req_type))
                        REQ_HEADER: begin
                            if (r_nc == CW'(MAX_NODES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                ls_we      = 1'b1;
                                ls_wa      = r_nc[NW-1:0];
                                ls_wd      = r_ec;
                                n_nc       = r_nc + CW'(1);
                                n_computed = 1'b0;
                            end
                        end
                        REQ_ENTRY: begin
                            if (r_nc == '0 || r_ec == EW'(MAX_ENTRIES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                adj_we     = 1'b1;
                                adj_wa     = r_ec[AW-1:0];
                                adj_wd     = i_neighbor_id;
                                n_ec       = r_ec + EW'(1);
                                n_computed = 1'b0;
                            end
                        end
                        REQ_RUN: begin
                            n_computed = 1'b1;
                            if (r_nc != '0) begin
                                n_state = S_DEG_LS;
                                n_v = '0;  n_e = '0;  n_cnt = '0;  n_maxd = '0;
                            end
                        end
                        REQ_QUERY: begin
                            core_ra = i_query_node;
                            n_valid = 1'b1;
                            n_qnode = i_query_node;
                            n_ok    = r_computed && (CW'(i_query_node) < r_nc);
                            n_ovq   = r_ovf;
                        end
                        default: ;
                    endcase
                end
            end
            // degree pass, lists are contiguous so r_e runs on
            S_DEG_LS: begin
                if (vp1 < r_nc) begin
                    ls_ra   = vp1[NW-1:0];
                    n_state = S_DEG_LSW;
                end else begin
                    n_end   = r_ec;
                    n_state = S_DEG_ADJ;
                end
            end
            S_DEG_LSW: begin
                n_end   = r_ls_q;
                n_state = S_DEG_ADJ;
            end
            S_DEG_ADJ: begin
                if (r_e < r_end) begin
                    adj_ra  = r_e[AW-1:0];
                    n_state = S_DEG_CNT;
                end else begin
                    deg_we = 1'b1;
                    deg_wa = r_v[NW-1:0];
                    deg_wd = r_cnt;
                    if (r_cnt > r_maxd) n_maxd = r_cnt;
                    n_cnt = '0;
                    n_v   = vp1;
                    if (vp1 == r_nc) begin
                        n_d     = '0;
                        n_state = S_BIN_CLR;
                    end else begin
                        n_state = S_DEG_LS;
                    end
                end
            end
            S_DEG_CNT: begin
                if (CW'(r_adj_q) < r_nc) n_cnt = r_cnt + EW'(1);
                n_e     = r_e + EW'(1);
                n_state = S_DEG_ADJ;
            end
            S_BIN_CLR: begin
                bin_we = 1'b1;
                bin_wa = r_d;
                bin_wd = '0;
                if (r_d == r_maxd) begin
                    n_v     = '0;
                    n_state = S_HIST_RD;
                end else begin
                    n_d = r_d + EW'(1);
                end
            end
            // histogram of degrees
            S_HIST_RD: begin
                deg_ra  = r_v[NW-1:0];
                n_state = S_HIST_BR;
            end
            S_HIST_BR: begin
                bin_ra  = r_deg_q;
                n_du    = r_deg_q;
                n_state = S_HIST_WR;
            end
            S_HIST_WR: begin
                bin_we = 1'b1;
                bin_wa = r_du;
                bin_wd = r_bin_q + EW'(1);
                n_v    = vp1;
                if (vp1 == r_nc) begin
                    n_d     = '0;
                    n_acc   = '0;
                    n_state = S_PFX_RD;
                end else begin
                    n_state = S_HIST_RD;
                end
            end
            // exclusive prefix sum
            S_PFX_RD: begin
                bin_ra  = r_d;
                n_state = S_PFX_WR;
            end
            S_PFX_WR: begin
                bin_we = 1'b1;
                bin_wa = r_d;
                bin_wd = r_acc;
                n_acc  = r_acc + r_bin_q;
                if (r_d == r_maxd) begin
                    n_v     = '0;
                    n_state = S_PLACE_RD;
                end else begin
                    n_d     = r_d + EW'(1);
                    n_state = S_PFX_RD;
                end
            end
            // bucket placement
            S_PLACE_RD: begin
                deg_ra  = r_v[NW-1:0];
                n_state = S_PLACE_BR;
            end
            S_PLACE_BR: begin
                bin_ra  = r_deg_q;
                n_du    = r_deg_q;
                n_state = S_PLACE_WR;
            end
            S_PLACE_WR: begin
                srt_we = 1'b1;
                srt_wa = r_bin_q[NW-1:0];
                srt_wd = r_v[NW-1:0];
                pos_we = 1'b1;
                pos_wa = r_v[NW-1:0];
                pos_wd = r_bin_q[NW-1:0];
                bin_we = 1'b1;
                bin_wa = r_du;
                bin_wd = r_bin_q + EW'(1);
                n_v    = vp1;
                if (vp1 == r_nc) begin
                    n_d     = r_maxd;
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_PLACE_RD;
                end
            end
            // shift bin starts back up by one
            S_SHIFT_RD: begin
                if (r_d == '0) begin
                    bin_we  = 1'b1;
                    bin_wa  = '0;
                    bin_wd  = '0;
                    n_i     = '0;
                    n_state = S_PEEL_RS;
                end else begin
                    bin_ra  = r_d - EW'(1);
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                bin_we  = 1'b1;
                bin_wa  = r_d;
                bin_wd  = r_bin_q;
                n_d     = r_d - EW'(1);
                n_state = S_SHIFT_RD;
            end
            // peeling in sorted order
            S_PEEL_RS: begin
                srt_ra  = r_i[NW-1:0];
                n_state = S_PEEL_V;
            end
            S_PEEL_V: begin
                n_pv    = r_srt_q;
                deg_ra  = r_srt_q;
                n_state = S_PEEL_DV;
            end
            S_PEEL_DV: begin
                n_dv    = r_deg_q;
                core_we = 1'b1;
                core_wa = r_pv;
                core_wd = r_deg_q;
                ls_ra   = r_pv;
                n_state = S_PEEL_LS;
            end
            S_PEEL_LS: begin
                n_e = r_ls_q;
                if (pvp1 < r_nc) begin
                    ls_ra   = pvp1[NW-1:0];
                    n_state = S_PEEL_LE;
                end else begin
                    n_end   = r_ec;
                    n_state = S_PEEL_ADJ;
                end
            end
            S_PEEL_LE: begin
                n_end   = r_ls_q;
                n_state = S_PEEL_ADJ;
            end
            S_PEEL_ADJ: begin
                if (r_e < r_end) begin
                    adj_ra  = r_e[AW-1:0];
                    n_state = S_PEEL_U;
                end else begin
                    n_i = ip1;
                    if (ip1 == r_nc) n_state = S_IDLE;
                    else             n_state = S_PEEL_RS;
                end
            end
            S_PEEL_U: begin
                n_u = r_adj_q;
                n_e = r_e + EW'(1);
                if (CW'(r_adj_q) < r_nc) begin
                    deg_ra  = r_adj_q;
                    n_state = S_PEEL_DU;
                end else begin
                    n_state = S_PEEL_ADJ;
                end
            end
            S_PEEL_DU: begin
                n_du = r_deg_q;
                if (r_deg_q > r_dv) begin
                    pos_ra  = r_u;
                    bin_ra  = r_deg_q;
                    n_state = S_PEEL_PW;
                end else begin
                    n_state = S_PEEL_ADJ;
                end
            end
            S_PEEL_PW: begin
                n_pu    = r_pos_q;
                n_pw    = r_bin_q[NW-1:0];
                srt_ra  = r_bin_q[NW-1:0];
                n_state = S_PEEL_W;
            end
            S_PEEL_W: begin
                bin_we = 1'b1;
                bin_wa = r_du;
                bin_wd = EW'(r_pw) + EW'(1);
                deg_we = 1'b1;
                deg_wa = r_u;
                deg_wd = r_du - EW'(1);
                if (r_srt_q != r_u) begin
                    srt_we  = 1'b1;
                    srt_wa  = r_pu;
                    srt_wd  = r_srt_q;
                    pos_we  = 1'b1;
                    pos_wa  = r_srt_q;
                    pos_wd  = r_pu;
                    n_state = S_PEEL_SW;
                end else begin
                    n_state = S_PEEL_ADJ;
                end
            end
            S_PEEL_SW: begin
                srt_we  = 1'b1;
                srt_wa  = r_pw;
                srt_wd  = r_u;
                pos_we  = 1'b1;
                pos_wa  = r_u;
                pos_wd  = r_pw;
                n_state = S_PEEL_ADJ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories, registered read
    always_ff @(posedge i_clk) begin
        if (adj_we)  m_adj[adj_wa]   <= adj_wd;
        if (ls_we)   m_ls[ls_wa]     <= ls_wd;
        if (deg_we)  m_deg[deg_wa]   <= deg_wd;
        if (bin_we)  m_bin[bin_wa]   <= bin_wd;
        if (srt_we)  m_srt[srt_wa]   <= srt_wd;
        if (pos_we)  m_pos[pos_wa]   <= pos_wd;
        if (core_we) m_core[core_wa] <= core_wd;
        r_adj_q  <= m_adj[adj_ra];
        r_ls_q   <= m_ls[ls_ra];
        r_deg_q  <= m_deg[deg_ra];
        r_bin_q  <= m_bin[bin_ra];
        r_srt_q  <= m_srt[srt_ra];
        r_pos_q  <= m_pos[pos_ra];
        r_core_q <= m_core[core_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nc       <= '0;
            r_ec       <= '0;
            r_computed <= 1'b0;
            r_ovf      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_nc       <= n_nc;
            r_ec       <= n_ec;
            r_computed <= n_computed;
            r_ovf      <= n_ovf;
            r_valid    <= n_valid;
        end
    end

    // payload and loop registers
    always_ff @(posedge i_clk) begin
        r_v <= n_v;  r_i <= n_i;  r_e <= n_e;  r_end <= n_end;  r_cnt <= n_cnt;
        r_maxd <= n_maxd;  r_d <= n_d;  r_acc <= n_acc;  r_dv <= n_dv;  r_du <= n_du;
        r_pv <= n_pv;  r_u <= n_u;  r_pu <= n_pu;  r_pw <= n_pw;
        r_ok <= n_ok;  r_ovq <= n_ovq;  r_qnode <= n_qnode;
    end

    assign o_valid      = r_valid;
    assign o_node_echo  = r_qnode;
    assign o_core_value = r_ok ? r_core_q : '0;
    assign o_in_range   = r_ok;
    assign o_overflow   = r_ovq;

    // a strobe only follows a taken query beat
    a_valid_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept && (i_req_type == REQ_QUERY)))
        else $error("result strobe without query");

    a_zero_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_core_value == '0))
        else $error("nonzero core out of range");

    a_busy_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(i_req_type == REQ_RUN))
        else $error("busy without run beat");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nc <= CW'(MAX_NODES)) && (r_ec <= EW'(MAX_ENTRIES)))
        else $error("load count beyond capacity");

endmodule
